// File: design/rmvs_pkg.sv
// Package for the running mean / variance statistics block.
// Widths, limits and the control state type shared by the top level and the
// serial divider and multiplier. No dependencies.
package rmvs_pkg;

  // field widths
  localparam int SAMPLE_W    = 16;
  localparam int MEAN_W      = 32;
  localparam int VAR_W       = 46;
  localparam int CNT_W       = 17;
  localparam int M2_W        = 62;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 128;

  // sample count limit; samples past it are dropped
  localparam int MAX_COUNT = 65536;

  // serial divider: quotient shift register, remainder and step counter
  localparam int DIV_Q_W        = 46;
  localparam int DIV_R_W        = 17;
  localparam int DIV_CNT_W      = 6;
  localparam int MEAN_DIV_STEPS = 32;
  localparam int VAR_DIV_STEPS  = 46;

  // serial multiplier: operand width and step counter
  localparam int MUL_W     = 32;
  localparam int MUL_CNT_W = 6;

  typedef enum logic [2:0] {
    ST_IDLE,    // waiting for a sample word
    ST_DIV,     // mean step division running
    ST_MSTART,  // new mean in place, start product
    ST_MUL,     // deviation product running
    ST_VAR,     // last sample taken, decide variance path
    ST_VDIV,    // variance division running
    ST_EMIT     // load the result register
  } state_t;

endpackage

// File: design/rmvs_div.sv
// Restoring divider, one quotient bit per cycle.
// Used for the mean step (delta / n) and the variance (M2 / (n-1)).
// Depends on rmvs_pkg.
module rmvs_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [rmvs_pkg::DIV_Q_W-1:0]   dividend,  // left aligned, MSB first
  input  logic [rmvs_pkg::DIV_R_W-1:0]   rem_init,  // partial remainder, below divisor
  input  logic [rmvs_pkg::DIV_R_W-1:0]   divisor,
  input  logic [rmvs_pkg::DIV_CNT_W-1:0] steps,
  output logic                           done,
  output logic [rmvs_pkg::DIV_Q_W-1:0]   quotient
);

  logic [rmvs_pkg::DIV_Q_W-1:0]   shreg;
  logic [rmvs_pkg::DIV_R_W-1:0]   rem;
  logic [rmvs_pkg::DIV_R_W-1:0]   dvsr;
  logic [rmvs_pkg::DIV_CNT_W-1:0] cnt;
  logic                           busy;

  logic [rmvs_pkg::DIV_R_W:0]     shifted;
  logic [rmvs_pkg::DIV_R_W:0]     diff;
  logic                           ge;

  // one trial subtraction per step
  assign shifted = {rem, shreg[rmvs_pkg::DIV_Q_W-1]};
  assign ge      = shifted >= {1'b0, dvsr};
  assign diff    = shifted - {1'b0, dvsr};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= steps;
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      busy <= (cnt != rmvs_pkg::DIV_CNT_W'(1));
      done <= (cnt == rmvs_pkg::DIV_CNT_W'(1));
    end else begin
      done <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= rem_init;
      dvsr  <= divisor;
    end else if (busy) begin
      shreg <= {shreg[rmvs_pkg::DIV_Q_W-2:0], ge};
      rem   <= ge ? diff[rmvs_pkg::DIV_R_W-1:0] : shifted[rmvs_pkg::DIV_R_W-1:0];
    end
  end

  assign quotient = shreg;

endmodule

// File: design/rmvs_mul.sv
// Shift-add multiplier, one multiplier bit per cycle.
// Forms the product of the two deviation magnitudes. Depends on rmvs_pkg.
module rmvs_mul (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [rmvs_pkg::MUL_W-1:0]     a,
  input  logic [rmvs_pkg::MUL_W-1:0]     b,
  output logic                           done,
  output logic [2*rmvs_pkg::MUL_W-1:0]   product
);

  logic [2*rmvs_pkg::MUL_W-1:0]   acc;
  logic [rmvs_pkg::MUL_W-1:0]     mcand;
  logic [rmvs_pkg::MUL_CNT_W-1:0] cnt;
  logic                           busy;
  logic [rmvs_pkg::MUL_W:0]       sum;

  // add multiplicand into the upper half when the low bit is set
  assign sum = {1'b0, acc[2*rmvs_pkg::MUL_W-1:rmvs_pkg::MUL_W]}
             + {1'b0, (acc[0] ? mcand : '0)};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= rmvs_pkg::MUL_CNT_W'(rmvs_pkg::MUL_W);
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      busy <= (cnt != rmvs_pkg::MUL_CNT_W'(1));
      done <= (cnt == rmvs_pkg::MUL_CNT_W'(1));
    end else begin
      done <= 1'b0;
    end
  end

  // datapath: shift right, sum enters at the top
  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= {{rmvs_pkg::MUL_W{1'b0}}, b};
      mcand <= a;
    end else if (busy) begin
      acc <= {sum, acc[rmvs_pkg::MUL_W-1:1]};
    end
  end

  assign product = acc;

endmodule

// File: design/running_mean_variance_stats_top.sv
// Running mean / variance statistics, top level.
// Uses rmvs_pkg, rmvs_div and rmvs_mul.
//
// Input stream (s_*): one sample word per set member; s_tlast marks the last
// sample of a set, s_tuser marks an empty set (sample ignored, zeros out).
// Output stream (m_*): one result word per set, on the last sample or on an
// empty-set word.
//
// Each sample runs a bit-serial division of the deviation by the new count
// and then a bit-serial deviation product; no new sample word is taken until
// both are done and the block is back in idle.
// On the last sample the variance M2/(n-1) takes another division, skipped
// when n is 1 or the variance saturates; m_tvalid rises once the emit state
// has loaded the result register.
// An empty-set word goes straight to the emit state.
// The result sits in an output register; while it waits for m_tready the
// block keeps taking and processing samples, and stalls only when a new
// result is ready and the old one has not been taken.
// Reset (rst, synchronous) clears all statistics and drops any pending word.
// Samples past 65536 in a set are dropped and set the overflow flag.
module running_mean_variance_stats_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [rmvs_pkg::IN_TDATA_W-1:0]     s_tdata,   // [15:0] sample
  input  logic                                s_tlast,   // is_last
  input  logic                                s_tuser,   // empty_set
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [rmvs_pkg::OUT_TDATA_W-1:0]    m_tdata    // [31:0] mean_value,
                                                         // [77:32] variance_value,
                                                         // [93:78] min_sample,
                                                         // [109:94] max_sample,
                                                         // [126:110] sample_count,
                                                         // [127] overflow_flag
);

  rmvs_pkg::state_t state, state_next;

  // statistics
  logic [rmvs_pkg::CNT_W-1:0]           count;
  logic [rmvs_pkg::MEAN_W-1:0]          mean;
  logic [rmvs_pkg::M2_W-1:0]            m2;
  logic signed [rmvs_pkg::SAMPLE_W-1:0] lo;
  logic signed [rmvs_pkg::SAMPLE_W-1:0] hi;
  logic                                 dropped;

  // per-sample working registers
  logic signed [rmvs_pkg::SAMPLE_W-1:0] samp;
  logic                                 last;
  logic                                 dneg;
  logic [rmvs_pkg::MEAN_W-1:0]          dmag;
  logic [rmvs_pkg::VAR_W-1:0]           var_res;

  logic accept, at_limit;
  logic div_start, div_done, mul_start, mul_done;
  logic [rmvs_pkg::DIV_Q_W-1:0]   div_dividend, div_q;
  logic [rmvs_pkg::DIV_R_W-1:0]   div_rem, div_dvsr;
  logic [rmvs_pkg::DIV_CNT_W-1:0] div_steps;
  logic [2*rmvs_pkg::MUL_W-1:0]   product;

  logic [rmvs_pkg::MEAN_W-1:0] x_in, x_cur, step, mean_step;
  logic [rmvs_pkg::MEAN_W:0]   delta_in, delta2;
  logic [rmvs_pkg::MEAN_W-1:0] dmag_in, d2mag;
  logic [rmvs_pkg::M2_W:0]     m2_sum;
  logic [rmvs_pkg::CNT_W-1:0]  cnt_m1;
  logic                        var_one, var_sat, out_free;

  assign accept   = s_tvalid && s_tready;
  assign at_limit = (count == rmvs_pkg::CNT_W'(rmvs_pkg::MAX_COUNT));
  assign out_free = !m_tvalid || m_tready;

  // deviation of the incoming sample from the current mean
  assign x_in     = {s_tdata, 16'b0};
  assign delta_in = {x_in[rmvs_pkg::MEAN_W-1], x_in} - {mean[rmvs_pkg::MEAN_W-1], mean};
  assign dmag_in  = delta_in[rmvs_pkg::MEAN_W] ? (~delta_in[rmvs_pkg::MEAN_W-1:0] + 1'b1)
                                               : delta_in[rmvs_pkg::MEAN_W-1:0];

  // mean update from the division result
  assign step      = div_q[rmvs_pkg::MEAN_W-1:0];
  assign mean_step = dneg ? (mean - step) : (mean + step);

  // deviation from the updated mean, same sign as the first one
  assign x_cur  = {samp, 16'b0};
  assign delta2 = {x_cur[rmvs_pkg::MEAN_W-1], x_cur} - {mean[rmvs_pkg::MEAN_W-1], mean};
  assign d2mag  = delta2[rmvs_pkg::MEAN_W] ? (~delta2[rmvs_pkg::MEAN_W-1:0] + 1'b1)
                                           : delta2[rmvs_pkg::MEAN_W-1:0];

  // M2 accumulate, product scaled down by 16 bits
  assign m2_sum = {1'b0, m2} + {{(rmvs_pkg::M2_W + 1 - 48){1'b0}}, product[63:16]};

  // variance path selection
  assign cnt_m1  = count - 1'b1;
  assign var_one = (count <= rmvs_pkg::CNT_W'(1));
  assign var_sat = ({1'b0, m2[rmvs_pkg::M2_W-1:rmvs_pkg::VAR_W]} >= cnt_m1);

  // divider operands: mean step in idle, variance otherwise
  always_comb begin
    if (state == rmvs_pkg::ST_IDLE) begin
      div_dividend = {dmag_in, {(rmvs_pkg::DIV_Q_W - rmvs_pkg::MEAN_W){1'b0}}};
      div_rem      = '0;
      div_dvsr     = count + 1'b1;
      div_steps    = rmvs_pkg::DIV_CNT_W'(rmvs_pkg::MEAN_DIV_STEPS);
    end else begin
      div_dividend = m2[rmvs_pkg::VAR_W-1:0];
      div_rem      = {1'b0, m2[rmvs_pkg::M2_W-1:rmvs_pkg::VAR_W]};
      div_dvsr     = cnt_m1;
      div_steps    = rmvs_pkg::DIV_CNT_W'(rmvs_pkg::VAR_DIV_STEPS);
    end
  end

  rmvs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .rem_init (div_rem),
    .divisor  (div_dvsr),
    .steps    (div_steps),
    .done     (div_done),
    .quotient (div_q)
  );

  rmvs_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (dmag),
    .b       (d2mag),
    .done    (mul_done),
    .product (product)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rmvs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and control
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    div_start  = 1'b0;
    mul_start  = 1'b0;
    unique case (state)
      rmvs_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_tuser) begin
            state_next = rmvs_pkg::ST_EMIT;
          end else if (!at_limit) begin
            div_start  = 1'b1;
            state_next = rmvs_pkg::ST_DIV;
          end else if (s_tlast) begin
            state_next = rmvs_pkg::ST_VAR;
          end
        end
      end
      rmvs_pkg::ST_DIV: begin
        if (div_done) state_next = rmvs_pkg::ST_MSTART;
      end
      rmvs_pkg::ST_MSTART: begin
        mul_start  = 1'b1;
        state_next = rmvs_pkg::ST_MUL;
      end
      rmvs_pkg::ST_MUL: begin
        if (mul_done) state_next = last ? rmvs_pkg::ST_VAR : rmvs_pkg::ST_IDLE;
      end
      rmvs_pkg::ST_VAR: begin
        if (var_one || var_sat) begin
          state_next = rmvs_pkg::ST_EMIT;
        end else begin
          div_start  = 1'b1;
          state_next = rmvs_pkg::ST_VDIV;
        end
      end
      rmvs_pkg::ST_VDIV: begin
        if (div_done) state_next = rmvs_pkg::ST_EMIT;
      end
      rmvs_pkg::ST_EMIT: begin
        if (out_free) state_next = rmvs_pkg::ST_IDLE;
      end
      default: state_next = rmvs_pkg::ST_IDLE;
    endcase
  end

  // statistics registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      mean    <= '0;
      m2      <= '0;
      lo      <= '0;
      hi      <= '0;
      dropped <= 1'b0;
    end else begin
      unique case (state)
        rmvs_pkg::ST_IDLE: begin
          if (accept && s_tuser) begin
            count   <= '0;
            mean    <= '0;
            m2      <= '0;
            lo      <= '0;
            hi      <= '0;
            dropped <= 1'b0;
          end else if (accept && at_limit) begin
            dropped <= 1'b1;
          end
        end
        rmvs_pkg::ST_DIV: begin
          if (div_done) mean <= mean_step;
        end
        rmvs_pkg::ST_MUL: begin
          if (mul_done) begin
            m2    <= m2_sum[rmvs_pkg::M2_W] ? {rmvs_pkg::M2_W{1'b1}}
                                            : m2_sum[rmvs_pkg::M2_W-1:0];
            count <= count + 1'b1;
            if (count == '0) begin
              lo <= samp;
              hi <= samp;
            end else begin
              if (samp < lo) lo <= samp;
              if (samp > hi) hi <= samp;
            end
          end
        end
        rmvs_pkg::ST_EMIT: begin
          if (out_free) begin
            count   <= '0;
            mean    <= '0;
            m2      <= '0;
            lo      <= '0;
            hi      <= '0;
            dropped <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // per-sample working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      samp <= s_tdata;
      last <= s_tlast;
      dneg <= delta_in[rmvs_pkg::MEAN_W];
      dmag <= dmag_in;
    end
    if (accept && s_tuser) begin
      var_res <= '0;
    end else if (state == rmvs_pkg::ST_VAR) begin
      var_res <= var_one ? '0 : {rmvs_pkg::VAR_W{1'b1}};
    end else if (state == rmvs_pkg::ST_VDIV && div_done) begin
      var_res <= div_q[rmvs_pkg::VAR_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == rmvs_pkg::ST_EMIT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == rmvs_pkg::ST_EMIT && out_free) begin
      m_tdata <= {dropped, count, hi, lo, var_res, mean};
    end
  end

endmodule

// File: tb/tb.sv
// Testbench for running_mean_variance_stats_top: Welford mean, variance, min, max.
// Needs rmvs_pkg and the block's RTL. A scoreboard class predicts each result
// word from the accepted sample words; plain tasks drive the input stream.
module tb;

  localparam int CLK_HALF       = 6;
  localparam int RANDOM_WORDS   = 1650;
  localparam int HOLD_CYCLES    = 2500;
  localparam int DRAIN_CYCLES   = 200;
  localparam int CYCLE_LIMIT    = 1_000_000;

  // one expected result word, split into its fields
  typedef struct packed {
    logic [rmvs_pkg::MEAN_W-1:0]   mean;
    logic [rmvs_pkg::VAR_W-1:0]    var_v;
    logic [rmvs_pkg::SAMPLE_W-1:0] lo;
    logic [rmvs_pkg::SAMPLE_W-1:0] hi;
    logic [rmvs_pkg::CNT_W-1:0]    cnt;
    logic                          ovf;
  } stats_t;

  // Welford statistics tracker and store of expected result words
  class welford_tracker;
    localparam longint unsigned M2_LIMIT  = (64'd1 << rmvs_pkg::M2_W) - 64'd1;
    localparam longint unsigned VAR_LIMIT = (64'd1 << rmvs_pkg::VAR_W) - 64'd1;

    stats_t               expected_stats[$];
    int unsigned          count;
    longint               mean;
    longint unsigned      m2;
    logic signed [15:0]   least;
    logic signed [15:0]   greatest;
    bit                   dropped;
    int                   errors;
    int                   words_in;
    int                   results_seen;

    function new();
      errors = 0;
      words_in = 0;
      results_seen = 0;
      clear();
    endfunction

    function void clear();
      count = 0;
      mean = 0;
      m2 = 0;
      least = '0;
      greatest = '0;
      dropped = 1'b0;
    endfunction

    // append an expected word at the tail of the store
    function void add_expected(stats_t e);
      expected_stats.insert(expected_stats.size(), e);
    endfunction

    function longint unsigned magnitude(longint v);
      return (v < 0) ? longint'(-v) : v;
    endfunction

    // one Welford update with the sample scaled to Q16.16
    function void fold_sample(logic signed [15:0] s);
      longint x, delta, delta2;
      longint unsigned dmag, step, prod;
      int unsigned n;
      x = longint'(s) * 65536;
      n = count + 1;
      delta = x - mean;
      dmag = magnitude(delta);
      step = dmag / n;
      if (delta < 0) mean = mean - longint'(step);
      else mean = mean + longint'(step);
      delta2 = x - mean;
      prod = (dmag * magnitude(delta2)) >> 16;
      if (prod > M2_LIMIT - m2) m2 = M2_LIMIT;
      else m2 = m2 + prod;
      if (count == 0) begin
        least = s;
        greatest = s;
      end else begin
        if (s < least) least = s;
        if (s > greatest) greatest = s;
      end
      count = n;
    endfunction

    // accepted input word: update statistics, queue a result if one is due
    function void note_word(logic [15:0] smp, bit last, bit empty);
      stats_t e;
      longint unsigned v;
      words_in++;
      if (empty) begin
        e = '0;
        add_expected(e);
        clear();
        return;
      end
      if (count >= rmvs_pkg::MAX_COUNT) dropped = 1'b1;
      else fold_sample(smp);
      if (!last) return;
      v = 0;
      if (count > 1) begin
        v = m2 / (count - 1);
        if (v > VAR_LIMIT) v = VAR_LIMIT;
      end
      e.mean  = mean[31:0];
      e.var_v = v[rmvs_pkg::VAR_W-1:0];
      e.lo    = least;
      e.hi    = greatest;
      e.cnt   = count[rmvs_pkg::CNT_W-1:0];
      e.ovf   = dropped;
      add_expected(e);
      clear();
    endfunction

    function void compare(string what, longint want, longint got);
      if (want != got) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
        errors++;
      end
    endfunction

    // accepted result word against the oldest expectation
    function void check_word(logic [rmvs_pkg::OUT_TDATA_W-1:0] d);
      stats_t e;
      results_seen++;
      if (expected_stats.size() == 0) begin
        $display("%0t: result word with none expected: expected nothing, actual %h",
                 $time, d);
        errors++;
        return;
      end
      e = expected_stats.pop_front();
      compare("mean_value", longint'($signed(e.mean)), longint'($signed(d[31:0])));
      compare("variance_value", longint'(e.var_v), longint'(d[77:32]));
      compare("min_sample", longint'($signed(e.lo)), longint'($signed(d[93:78])));
      compare("max_sample", longint'($signed(e.hi)), longint'($signed(d[109:94])));
      compare("sample_count", longint'(e.cnt), longint'(d[126:110]));
      compare("overflow_flag", longint'(e.ovf), longint'(d[127]));
    endfunction

    function int pending();
      return expected_stats.size();
    endfunction
  endclass

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [rmvs_pkg::IN_TDATA_W-1:0]  s_tdata = '0;   // [15:0] sample
  logic                             s_tlast = 1'b0; // is_last
  logic                             s_tuser = 1'b0; // empty_set
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [rmvs_pkg::OUT_TDATA_W-1:0] m_tdata;        // [31:0] mean, [77:32] variance,
                                                    // [93:78] min, [109:94] max,
                                                    // [126:110] count, [127] overflow

  welford_tracker tracker;
  bit  tx_idle = 1'b0;
  bit  rx_idle = 1'b1;
  bit  hold_req = 1'b0;
  bit  hold_on = 1'b0;
  int  rx_wait = 0;
  int  words_sent = 0;
  int  sets_done = 0;
  int  cycle_count = 0;

  running_mean_variance_stats_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // result side: check each accepted word, then stall a random number of cycles while rx_idle is set
  always @(posedge clk) begin
    if (rst) begin
      rx_wait = 0;
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        tracker.check_word(m_tdata);
        rx_wait = rx_idle ? $urandom_range(0, 9) : 0;
      end else if (rx_wait > 0) begin
        rx_wait = rx_wait - 1;
      end
      m_tready <= (rx_wait == 0) && !hold_on;
    end
  end

  // long receiver hold-off, counted here while the sender keeps going
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_on) begin
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
        hold_req <= 1'b0;
      end
    end
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
             tracker.pending());
    $display("Some tests failed");
    $finish;
  end

  // offer one word, after a random gap when tx_idle is set, and wait for the handshake
  task automatic send_word(input logic [15:0] smp, input bit last, input bit empty);
    int gap;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tlast  <= last;
    s_tuser  <= empty;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.note_word(smp, last, empty);
    words_sent++;
  endtask

  // sample content: full range, extremes, or a cluster around a base value
  function automatic logic [15:0] pick_sample(int style, logic [15:0] base);
    case (style)
      1: begin
        case ($urandom_range(0, 3))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      2: return base + 16'($urandom_range(0, 31)) - 16'd16;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_set(input int len);
    int style;
    logic [15:0] base;
    style = $urandom_range(0, 2);
    base = 16'($urandom);
    for (int i = 0; i < len; i++) send_word(pick_sample(style, base), i == len - 1, 1'b0);
  endtask

  initial begin
    int kind;
    int len;
    tracker = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty marks, single samples at the extremes, variance
    // saturation, a set discarded by an empty mark, small alternating set
    send_word(16'h7FFF, 1'b1, 1'b1);
    send_word(16'h8000, 1'b1, 1'b0);
    send_word(16'h7FFF, 1'b1, 1'b0);
    send_word(16'h8000, 1'b0, 1'b0);
    send_word(16'h7FFF, 1'b1, 1'b0);
    send_word(16'h7FFF, 1'b0, 1'b0);
    send_word(16'h8000, 1'b1, 1'b0);
    send_word(16'h0000, 1'b0, 1'b0);
    send_word(16'h0000, 1'b0, 1'b0);
    send_word(16'h0000, 1'b1, 1'b0);
    send_word(16'd5, 1'b0, 1'b0);
    send_word(16'd7, 1'b0, 1'b0);
    send_word(16'hFFFF, 1'b0, 1'b1);
    send_word(16'd100, 1'b1, 1'b0);
    send_word(16'hFFFF, 1'b0, 1'b0);
    send_word(16'h0001, 1'b0, 1'b0);
    send_word(16'hFFFF, 1'b0, 1'b0);
    send_word(16'h0001, 1'b1, 1'b0);
    send_word(16'h5555, 1'b0, 1'b1);
    send_word(16'hAAAA, 1'b1, 1'b0);

    // random sets with empty marks and aborted sets mixed in
    while (words_sent < RANDOM_WORDS + 20) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle <= ($urandom_range(0, 3) != 0);
      if (sets_done == 60) hold_req <= 1'b1;
      kind = $urandom_range(0, 99);
      if (kind < 5) begin
        send_word(16'($urandom), 1'($urandom_range(0, 1)), 1'b1);
      end else if (kind < 9) begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) send_word(16'($urandom), 1'b0, 1'b0);
        send_word(16'($urandom), 1'($urandom_range(0, 1)), 1'b1);
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        send_set(len);
      end
      sets_done++;
    end

    // closing short set with gaps on the input side
    tx_idle = 1'b1;
    send_set(3);
    s_tvalid <= 1'b0;

    // drain, then let any stray result show up
    while (tracker.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d input words in %0d random sets and %0d result words,",
             tracker.words_in, sets_done, tracker.results_seen);
    $display("with empty-set marks, extreme and clustered samples and a %0d-cycle hold-off.",
             HOLD_CYCLES);
    if (tracker.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
